// File: sv/hkb_pkg.sv
`timescale 1ns / 1ps

package hkb_pkg;

    // Hash arithmetic
    localparam int unsigned HKB_HASH_W  = 32;
    localparam int unsigned HKB_BKT_W   = 21;
    localparam int unsigned HKB_CNT_W   = 3;
    localparam logic [HKB_HASH_W-1:0] HKB_MULT = 32'h5bd1e995;
    localparam int unsigned HKB_MIX_SHIFT = 24;
    localparam int unsigned HKB_FIN_SHIFT_A = 13;
    localparam int unsigned HKB_FIN_SHIFT_B = 15;

    // Configuration port
    localparam int unsigned HKB_ADDR_W = 3;
    localparam int unsigned HKB_DATA_W = 32;
    localparam logic [HKB_ADDR_W-1:0] HKB_ADDR_BUCKET = 3'd0;
    localparam logic [HKB_BKT_W-1:0]  HKB_BUCKET_RESET = 21'd31;

    // Word queue between classifier and mixer (power of two)
    localparam int unsigned HKB_QUEUE_DEPTH = 4;

    // Word operation codes
    localparam logic [1:0] OP_BLOCK = 2'd0;  // full four-byte block
    localparam logic [1:0] OP_TAIL  = 2'd1;  // one to three tail bytes, pre-masked
    localparam logic [1:0] OP_FIN   = 2'd2;  // empty last word, finalize only

    typedef struct packed {
        logic [1:0]            op;
        logic                  last;
        logic [HKB_HASH_W-1:0] word;
    } t_q_entry;

    typedef struct packed {
        logic                  valid;
        t_q_entry              entry;
    } t_q_head;

    typedef struct packed {
        logic                  start;
        logic [HKB_HASH_W-1:0] hash;
    } t_div_req;

endpackage

// File: sv/hkb_front.sv
`timescale 1ns / 1ps

module hkb_front
    import hkb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = HKB_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [HKB_HASH_W-1:0] i_key_word,
    input  logic [HKB_CNT_W-1:0]  i_byte_count,
    input  logic                  i_last,
    output t_q_head               o_head,
    input  logic                  i_pop
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_q_entry           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    t_q_entry           w_entry;
    logic               w_full;
    logic               w_push;
    logic               w_pop;

    // Classify the word and mask off bytes past the tail
    always_comb begin
        w_entry.last = i_last;
        w_entry.word = i_key_word;
        w_entry.op   = OP_BLOCK;
        if (i_last) begin
            case (i_byte_count) inside
                3'd0: begin
                    w_entry.op   = OP_FIN;
                    w_entry.word = '0;
                end
                3'd1: begin
                    w_entry.op   = OP_TAIL;
                    w_entry.word = i_key_word & 32'h0000_00ff;
                end
                3'd2: begin
                    w_entry.op   = OP_TAIL;
                    w_entry.word = i_key_word & 32'h0000_ffff;
                end
                3'd3: begin
                    w_entry.op   = OP_TAIL;
                    w_entry.word = i_key_word & 32'h00ff_ffff;
                end
                [3'd4:3'd7]: begin
                    w_entry.op   = OP_BLOCK;
                end
                default: begin
                    w_entry.op   = OP_BLOCK;
                end
            endcase
        end
    end

    assign w_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stall = w_full;
    assign w_push  = i_valid && !w_full;
    assign w_pop   = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = w_push ? PTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? PTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (w_pop && !w_push) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_entry;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

endmodule

// File: sv/hkb_back.sv
`timescale 1ns / 1ps

module hkb_back
    import hkb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_q_head  i_head,
    output logic     o_pop,
    input  logic     i_div_ready,
    output t_div_req o_div_req
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_K2   = 2'd1;
    localparam logic [1:0] ST_F1   = 2'd2;
    localparam logic [1:0] ST_F2   = 2'd3;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [HKB_HASH_W-1:0] r_h;
    logic [HKB_HASH_W-1:0] n_h;
    logic [HKB_HASH_W-1:0] r_k;
    logic [HKB_HASH_W-1:0] n_k;
    logic                  r_last;
    logic                  n_last;
    logic [HKB_HASH_W-1:0] w_mul_a;
    logic [HKB_HASH_W-1:0] w_mul_b;
    logic [HKB_HASH_W-1:0] w_prod_a;
    logic [HKB_HASH_W-1:0] w_prod_b;
    logic [HKB_HASH_W-1:0] w_tail;

    assign w_tail = (i_head.entry.op == OP_TAIL) ? i_head.entry.word : '0;

    // Two constant multipliers: one on the running hash, one on the block word
    always_comb begin
        w_mul_a = r_h;
        w_mul_b = r_k ^ (r_k >> HKB_MIX_SHIFT);
        if (r_state == ST_IDLE) begin
            w_mul_a = r_h ^ w_tail;
            w_mul_b = i_head.entry.word;
        end else if (r_state == ST_F1) begin
            w_mul_a = r_h ^ (r_h >> HKB_FIN_SHIFT_A);
        end
    end

    assign w_prod_a = w_mul_a * HKB_MULT;
    assign w_prod_b = w_mul_b * HKB_MULT;

    always_comb begin
        n_state         = r_state;
        n_h             = r_h;
        n_k             = r_k;
        n_last          = r_last;
        o_pop           = 1'b0;
        o_div_req.start = 1'b0;
        o_div_req.hash  = r_h ^ (r_h >> HKB_FIN_SHIFT_B);
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop  = 1'b1;
                    n_last = i_head.entry.last;
                    unique case (i_head.entry.op)
                        OP_BLOCK: begin
                            n_h     = w_prod_a;
                            n_k     = w_prod_b;
                            n_state = ST_K2;
                        end
                        OP_TAIL: begin
                            n_h     = w_prod_a;
                            n_state = ST_F1;
                        end
                        OP_FIN: begin
                            n_state = ST_F1;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_K2: begin
                n_h     = r_h ^ w_prod_b;
                n_state = r_last ? ST_F1 : ST_IDLE;
            end
            ST_F1: begin
                n_h     = w_prod_a;
                n_state = ST_F2;
            end
            ST_F2: begin
                // hold the finished hash until the divider is free
                if (i_div_ready) begin
                    o_div_req.start = 1'b1;
                    n_h             = '0;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_h     <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_h     <= n_h;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
    end

endmodule

// File: sv/hkb_mod.sv
`timescale 1ns / 1ps

module hkb_mod
    import hkb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_div_req              i_req,
    output logic                  o_ready,
    input  logic [HKB_BKT_W-1:0]  i_divisor,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [HKB_HASH_W-1:0] o_hash_value,
    output logic [HKB_BKT_W-1:0]  o_bucket_index
);

    localparam int unsigned STEP_W = $clog2(HKB_HASH_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [STEP_W-1:0]     r_step;
    logic [STEP_W-1:0]     n_step;
    logic [HKB_HASH_W-1:0] r_hash;
    logic [HKB_HASH_W-1:0] n_hash;
    logic [HKB_HASH_W-1:0] r_dividend;
    logic [HKB_HASH_W-1:0] n_dividend;
    logic [HKB_BKT_W-1:0]  r_rem;
    logic [HKB_BKT_W-1:0]  n_rem;
    logic [HKB_BKT_W-1:0]  r_div;
    logic [HKB_BKT_W-1:0]  n_div;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [HKB_HASH_W-1:0] r_out_hash;
    logic [HKB_BKT_W-1:0]  r_out_bucket;
    logic                  w_load;
    logic [HKB_BKT_W:0]    w_trial;

    // One restoring step a cycle: shift in the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_dividend[HKB_HASH_W-1]};
    assign w_load  = (r_state == ST_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_hash     = r_hash;
        n_dividend = r_dividend;
        n_rem      = r_rem;
        n_div      = r_div;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.start) begin
                    n_hash     = i_req.hash;
                    n_dividend = i_req.hash;
                    n_rem      = '0;
                    n_div      = i_divisor;
                    n_step     = '1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_trial >= {1'b0, r_div}) begin
                    n_rem = HKB_BKT_W'(w_trial - {1'b0, r_div});
                end else begin
                    n_rem = w_trial[HKB_BKT_W-1:0];
                end
                n_dividend = r_dividend << 1;
                n_step     = STEP_W'(r_step - 1'b1);
                if (r_step == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_hash     <= n_hash;
        r_dividend <= n_dividend;
        r_rem      <= n_rem;
        r_div      <= n_div;
        if (w_load) begin
            r_out_hash   <= r_hash;
            r_out_bucket <= r_rem;
        end
    end

    assign o_ready        = (r_state == ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_hash_value   = r_out_hash;
    assign o_bucket_index = r_out_bucket;

endmodule

// File: sv/string_key_hash_and_bucket_core.sv
`timescale 1ns / 1ps

// Key hash and bucket index unit (MurmurHash2 mix, zero start, 13/15 finalization).
// Input channel: i_valid / o_stall carries key words, little-endian, first byte in
// bits 7:0. i_last marks the final word of a key; on that word i_byte_count gives
// its valid bytes (0 to 4, larger counts act as 4). Words that are not last give no
// result. Output channel: o_valid / i_stall carries one word per key: the hash and
// the hash modulo bucket_count (a count of zero acts as one).
// bucket_count sits at byte address 0 of the APB-style port; write it only while idle.
// Flow: a full block passes through the IDLE and K2 states of the mixer, which holds
// one constant multiplier on the running hash and one on the block word. The last
// word adds the F1 and F2 finalization states, then the bit-serial modulo unit runs
// one restoring step for each of the 32 dividend bits. Words of the next key keep
// flowing through the mixer while the modulo unit works; the modulo unit takes a new
// hash only once it is idle again.
// A four-entry word queue decouples input from the mixer. A result waiting under
// i_stall holds in the output register; the modulo unit and then the mixer back up
// behind it, and o_stall rises once the queue fills.
// Reset clears the running hash, the queue, the pipeline and o_valid, and sets
// bucket_count to 31.

module string_key_hash_and_bucket_core
    import hkb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = HKB_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input words
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [HKB_HASH_W-1:0] i_key_word,
    input  logic [HKB_CNT_W-1:0]  i_byte_count,
    input  logic                  i_last,
    // results
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [HKB_HASH_W-1:0] o_hash_value,
    output logic [HKB_BKT_W-1:0]  o_bucket_index,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [HKB_ADDR_W-1:0] paddr,
    input  logic [HKB_DATA_W-1:0] pwdata,
    output logic [HKB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [HKB_BKT_W-1:0] r_bucket_count;
    logic [HKB_BKT_W-1:0] w_divisor;
    logic                 w_cfg_write;
    t_q_head              w_head;
    logic                 w_pop;
    t_div_req             w_div_req;
    logic                 w_div_ready;

    // Configuration register
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready && (paddr == HKB_ADDR_BUCKET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= HKB_BUCKET_RESET;
        end else if (w_cfg_write) begin
            r_bucket_count <= pwdata[HKB_BKT_W-1:0];
        end
    end

    assign prdata = (paddr == HKB_ADDR_BUCKET)
                  ? {{(HKB_DATA_W-HKB_BKT_W){1'b0}}, r_bucket_count} : '0;

    // a zero bucket count acts as one
    assign w_divisor = (r_bucket_count == '0) ? HKB_BKT_W'(1) : r_bucket_count;

    // Classify words and queue them
    hkb_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_key_word   (i_key_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // Mix blocks and tails, finalize
    hkb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_div_ready (w_div_ready),
        .o_div_req   (w_div_req)
    );

    // Bucket index and output register
    hkb_mod u_mod (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (w_div_req),
        .o_ready        (w_div_ready),
        .i_divisor      (w_divisor),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_hash_value   (o_hash_value),
        .o_bucket_index (o_bucket_index)
    );

`ifndef SYNTH
    // the mixer hands over a hash only when the modulo unit is free
    a_div_start_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> w_div_ready)
        else $error("hash handed over while modulo unit busy");

    // the mixer never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("pop from empty word queue");

    // a delivered bucket index lies below the bucket count
    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bucket_index < w_divisor))
        else $error("bucket index out of range");

    // no result is pending right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");
`endif

endmodule
